// File: design/vnf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vnf_pkg : shared types, constants and arithmetic helpers
// Fixed-point formats, the pipeline item, the per-octave settings and the
// hash, fade and blend functions used by the value-noise shader.
// ----------------------------------------------------------------------------
package vnf_pkg;

   localparam int MAX_OCTAVES_DEF = 8;
   localparam int FRAC_BITS       = 16;
   localparam int COORD_W         = 48;
   // Sized for the largest octave count the block supports.
   localparam int WSUM_W          = 36;
   localparam int ACC_W           = WSUM_W + FRAC_BITS;

   localparam logic [31:0] HASH_KX   = 32'd374761393;
   localparam logic [31:0] HASH_KY   = 32'd668265263;
   localparam logic [31:0] HASH_KS   = 32'd1274126177;
   localparam logic [31:0] HASH_MASK = 32'h7fffffff;
   localparam logic [31:0] SEED_STEP = 32'd31;
   localparam logic [31:0] Q16_ONE   = 32'h0001_0000;
   localparam logic [16:0] FONE      = 17'h1_0000;

   typedef enum logic [2:0] {
      REG_SEED,
      REG_OCTAVES,
      REG_STEP_X,
      REG_STEP_Y,
      REG_LACUNARITY,
      REG_PERSISTENCE,
      REG_COLOR_START,
      REG_COLOR_END
   } vnf_reg_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [ACC_W-1:0]   acc;
      logic [WSUM_W-1:0]  wsum;
   } vnf_item_type;

   typedef struct packed {
      logic [31:0] freq;
      logic [31:0] amp;
      logic [31:0] seed_term;
      logic        active;
   } vnf_oct_cfg_type;

   function automatic logic [31:0] scale_sat(logic [31:0] v, logic [15:0] m, int sh);
      logic [47:0] p;
      logic [47:0] s;
      p = {16'b0, v} * {32'b0, m};
      s = p >> sh;
      return (|s[47:32]) ? 32'hffff_ffff : s[31:0];
   endfunction

   function automatic logic [31:0] mix13(logic [31:0] h);
      return h ^ (h >> 13);
   endfunction

   function automatic logic [FRAC_BITS-1:0] corner(logic [31:0] m);
      logic [31:0] h;
      h = (m ^ (m >> 16)) & HASH_MASK;
      return h[30 -: FRAC_BITS];
   endfunction

   function automatic logic [16:0] fade_tail(logic [15:0] f, logic [15:0] f2);
      logic [17:0] fac;
      logic [33:0] p;
      fac = 18'h3_0000 - {1'b0, f, 1'b0};
      p   = {18'b0, f2} * {16'b0, fac};
      return p[32:16];
   endfunction

   function automatic logic [15:0] blend(logic [15:0] a, logic [15:0] b, logic [16:0] t);
      logic [32:0] pa;
      logic [32:0] pb;
      logic [33:0] s;
      pa = {17'b0, a} * {16'b0, FONE - t};
      pb = {17'b0, b} * {16'b0, t};
      s  = {1'b0, pa} + {1'b0, pb};
      return s[31:16];
   endfunction

endpackage
`default_nettype wire

// File: design/vnf_octave.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vnf_octave : one noise octave in seven register stages
// Scales the coordinate, hashes the four lattice corners, fades and blends
// them, and, if the octave is active, adds the weighted value to the running sums of the item.
// ----------------------------------------------------------------------------
module vnf_octave import vnf_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire vnf_oct_cfg_type cfg,
   input  wire logic            in_valid,
   input  wire vnf_item_type    in_item,
   output logic                 out_valid,
   output vnf_item_type         out_item
);

   typedef struct packed {
      vnf_item_type item;
      logic [55:0]  wx;
      logic [55:0]  px;
      logic [55:0]  wy;
      logic [55:0]  py;
   } sa_type;

   typedef struct packed {
      vnf_item_type item;
      logic [31:0]  ix;
      logic [31:0]  iy;
      logic [15:0]  fx;
      logic [15:0]  fy;
   } sb_type;

   typedef struct packed {
      vnf_item_type item;
      logic [31:0]  hx;
      logic [31:0]  hy;
      logic [15:0]  fx;
      logic [15:0]  fy;
      logic [15:0]  f2x;
      logic [15:0]  f2y;
   } sc_type;

   typedef struct packed {
      vnf_item_type item;
      logic [31:0]  m00;
      logic [31:0]  m10;
      logic [31:0]  m01;
      logic [31:0]  m11;
      logic [16:0]  sx;
      logic [16:0]  sy;
   } sd_type;

   typedef struct packed {
      vnf_item_type item;
      logic [15:0]  bx0;
      logic [15:0]  bx1;
      logic [16:0]  sy;
   } se_type;

   typedef struct packed {
      vnf_item_type item;
      logic [15:0]  n;
   } sf_type;

   sa_type       sa_in, sa_ff;
   sb_type       sb_in, sb_ff;
   sc_type       sc_in, sc_ff;
   sd_type       sd_in, sd_ff;
   se_type       se_in, se_ff;
   sf_type       sf_in, sf_ff;
   vnf_item_type sg_in, sg_ff;
   logic [6:0]   vld_ff;
   logic [55:0]  xc, yc;
   logic [31:0]  fsq_x, fsq_y;
   logic [31:0]  h00, h10, h01, h11;
   logic [47:0]  wprod;

   always_comb begin
      sa_in.item = in_item;
      sa_in.wx   = {32'b0, in_item.x[47:24]} * {24'b0, cfg.freq};
      sa_in.px   = {32'b0, in_item.x[23:0]}  * {24'b0, cfg.freq};
      sa_in.wy   = {32'b0, in_item.y[47:24]} * {24'b0, cfg.freq};
      sa_in.py   = {32'b0, in_item.y[23:0]}  * {24'b0, cfg.freq};
   end

   always_comb begin
      xc = (sa_ff.wx << 8) + (sa_ff.px >> 16);
      yc = (sa_ff.wy << 8) + (sa_ff.py >> 16);
      sb_in.item = sa_ff.item;
      sb_in.ix   = xc[55:24];
      sb_in.iy   = yc[55:24];
      sb_in.fx   = xc[23 -: FRAC_BITS];
      sb_in.fy   = yc[23 -: FRAC_BITS];
   end

   always_comb begin
      fsq_x = {16'b0, sb_ff.fx} * {16'b0, sb_ff.fx};
      fsq_y = {16'b0, sb_ff.fy} * {16'b0, sb_ff.fy};
      sc_in.item = sb_ff.item;
      sc_in.hx   = sb_ff.ix * HASH_KX;
      sc_in.hy   = sb_ff.iy * HASH_KY;
      sc_in.fx   = sb_ff.fx;
      sc_in.fy   = sb_ff.fy;
      sc_in.f2x  = fsq_x[31:16];
      sc_in.f2y  = fsq_y[31:16];
   end

   // Corner index plus one is folded in as an added hash constant.
   always_comb begin
      h00 = sc_ff.hx + sc_ff.hy + cfg.seed_term;
      h10 = h00 + HASH_KX;
      h01 = h00 + HASH_KY;
      h11 = h00 + HASH_KX + HASH_KY;
      sd_in.item = sc_ff.item;
      sd_in.m00  = mix13(h00) * HASH_KS;
      sd_in.m10  = mix13(h10) * HASH_KS;
      sd_in.m01  = mix13(h01) * HASH_KS;
      sd_in.m11  = mix13(h11) * HASH_KS;
      sd_in.sx   = fade_tail(sc_ff.fx, sc_ff.f2x);
      sd_in.sy   = fade_tail(sc_ff.fy, sc_ff.f2y);
   end

   always_comb begin
      se_in.item = sd_ff.item;
      se_in.bx0  = blend(corner(sd_ff.m00), corner(sd_ff.m10), sd_ff.sx);
      se_in.bx1  = blend(corner(sd_ff.m01), corner(sd_ff.m11), sd_ff.sx);
      se_in.sy   = sd_ff.sy;
   end

   always_comb begin
      sf_in.item = se_ff.item;
      sf_in.n    = blend(se_ff.bx0, se_ff.bx1, se_ff.sy);
   end

   always_comb begin
      wprod = {32'b0, sf_ff.n} * {16'b0, cfg.amp};
      sg_in = sf_ff.item;
      if (cfg.active) begin
         sg_in.acc  = sf_ff.item.acc + ACC_W'(wprod);
         sg_in.wsum = sf_ff.item.wsum + WSUM_W'(cfg.amp);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa_ff <= sa_in;
         sb_ff <= sb_in;
         sc_ff <= sc_in;
         sd_ff <= sd_in;
         se_ff <= se_in;
         sf_ff <= sf_in;
         sg_ff <= sg_in;
      end
   end

   assign out_valid = vld_ff[6];
   assign out_item  = sg_ff;

endmodule
`default_nettype wire

// File: design/vnf_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vnf_divider : pipelined restoring divider for the weighted noise sum
// One quotient bit per stage after a saturation check; the quotient is
// clamped to the largest Q0.16 value.
// ----------------------------------------------------------------------------
module vnf_divider import vnf_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire logic [ACC_W-1:0]     in_acc,
   input  wire logic [WSUM_W-1:0]    in_wsum,
   output logic                      out_valid,
   output logic [FRAC_BITS-1:0]      out_q
);

   localparam int STAGES = FRAC_BITS + 1;

   typedef struct packed {
      logic [ACC_W-1:0]     rem;
      logic [WSUM_W-1:0]    den;
      logic [FRAC_BITS-1:0] quo;
      logic                 sat;
   } div_type;

   div_type st_in  [STAGES];
   div_type st_ff  [STAGES];
   logic    vld_ff [STAGES];

   always_comb begin
      st_in[0].rem = in_acc;
      st_in[0].den = in_wsum;
      st_in[0].quo = '0;
      st_in[0].sat = in_acc >= (ACC_W'(in_wsum) << FRAC_BITS);
   end

   for (genvar j = 1; j < STAGES; j++) begin : g_bit
      logic [ACC_W-1:0] trial;
      always_comb begin
         trial    = ACC_W'(st_ff[j-1].den) << (FRAC_BITS - j);
         st_in[j] = st_ff[j-1];
         if (st_ff[j-1].rem >= trial) begin
            st_in[j].rem                 = st_ff[j-1].rem - trial;
            st_in[j].quo[FRAC_BITS - j]  = 1'b1;
         end
      end
   end

   for (genvar j = 0; j < STAGES; j++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= (j == 0) ? in_valid : vld_ff[(j == 0) ? 0 : j - 1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[j] <= st_in[j];
         end
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_q     = st_ff[STAGES-1].sat ? '1 : st_ff[STAGES-1].quo;

endmodule
`default_nettype wire

// File: design/value_noise_fbm_shader.sv
`default_nettype none
// ----------------------------------------------------------------------------
// value_noise_fbm_shader : fractal value-noise colour generator
// Turns a pixel coordinate into a noise level and a blended RGBA colour.
// ----------------------------------------------------------------------------
// The shader takes one pixel item per clock while its output buffer is not
// full and returns one result item per clock while the receiver takes them.
// The pipeline has one input multiply stage, seven stages for each
// octave unit, seventeen divider stages and one colour stage. Unused
// octave units still pass the item along. Settings are held in registers;
// the per-octave frequency and amplitude are derived from them in a chain
// of registers that is always ahead of any item, so pixels may follow a
// register write straight away. A two-entry output buffer keeps the input
// ready while one result waits to be taken.
module value_noise_fbm_shader import vnf_pkg::*; #(
   parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // pixel_x [15:0], pixel_y [31:16]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // pixel_rgba [31:0], noise_level [47:32]
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_OCTAVES + 1);

   typedef struct packed {
      logic [15:0] level;
      logic [31:0] rgba;
   } rsp_type;

   logic [31:0] seed_ff, step_x_ff, step_y_ff, color_start_ff, color_end_ff;
   logic [3:0]  octave_count_ff;
   logic [15:0] lacunarity_ff, persistence_ff;

   logic [31:0]      freq_ff  [MAX_OCTAVES];
   logic [31:0]      amp_ff   [MAX_OCTAVES];
   logic [31:0]      sterm_ff [MAX_OCTAVES];
   vnf_oct_cfg_type  oct_cfg  [MAX_OCTAVES];
   logic             oct_v    [MAX_OCTAVES+1];
   vnf_item_type     oct_item [MAX_OCTAVES+1];
   logic [4:0]       cnt_ext;
   logic [CNT_W-1:0] cnt_eff;

   logic                 en;
   logic                 s0_v_ff;
   vnf_item_type         s0_in, s0_ff;
   logic                 div_v;
   logic [FRAC_BITS-1:0] div_q;
   logic                 cs_v_ff;
   rsp_type              cs_in, cs_ff;
   logic                 out_v_ff, skid_v_ff;
   rsp_type              out_ff, skid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff         <= '0;
         octave_count_ff <= 4'd1;
         step_x_ff       <= 32'd65536;
         step_y_ff       <= 32'd65536;
         lacunarity_ff   <= 16'd8192;
         persistence_ff  <= 16'd8192;
         color_start_ff  <= '0;
         color_end_ff    <= 32'hffff_ffff;
      end else if (csr_we) begin
         case (vnf_reg_type'(csr_index))
            REG_SEED:        seed_ff         <= csr_wdata;
            REG_OCTAVES:     octave_count_ff <= csr_wdata[3:0];
            REG_STEP_X:      step_x_ff       <= csr_wdata;
            REG_STEP_Y:      step_y_ff       <= csr_wdata;
            REG_LACUNARITY:  lacunarity_ff   <= csr_wdata[15:0];
            REG_PERSISTENCE: persistence_ff  <= csr_wdata[15:0];
            REG_COLOR_START: color_start_ff  <= csr_wdata;
            REG_COLOR_END:   color_end_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (octave_count_ff == 4'd0) begin
         cnt_ext = 5'd1;
      end else if ({1'b0, octave_count_ff} > 5'(MAX_OCTAVES)) begin
         cnt_ext = 5'(MAX_OCTAVES);
      end else begin
         cnt_ext = {1'b0, octave_count_ff};
      end
      cnt_eff = CNT_W'(cnt_ext);
   end

   for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_chain
      always_ff @(posedge clock) begin
         if (i == 0) begin
            freq_ff[i] <= Q16_ONE;
            amp_ff[i]  <= Q16_ONE;
         end else begin
            freq_ff[i] <= scale_sat(freq_ff[(i == 0) ? 0 : i - 1], lacunarity_ff, 12);
            amp_ff[i]  <= scale_sat(amp_ff[(i == 0) ? 0 : i - 1], persistence_ff, 14);
         end
         sterm_ff[i] <= (seed_ff + SEED_STEP * 32'(i)) * HASH_KS;
      end
      assign oct_cfg[i].freq      = freq_ff[i];
      assign oct_cfg[i].amp       = amp_ff[i];
      assign oct_cfg[i].seed_term = sterm_ff[i];
      assign oct_cfg[i].active    = CNT_W'(i) < cnt_eff;
   end

   assign en         = !skid_v_ff;
   assign req_tready = en;

   always_comb begin
      s0_in.x    = {32'b0, req_tdata[15:0]}  * {16'b0, step_x_ff};
      s0_in.y    = {32'b0, req_tdata[31:16]} * {16'b0, step_y_ff};
      s0_in.acc  = '0;
      s0_in.wsum = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (en) begin
         s0_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff <= s0_in;
      end
   end

   assign oct_v[0]    = s0_v_ff;
   assign oct_item[0] = s0_ff;

   for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_octave
      vnf_octave u_octave (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .cfg       (oct_cfg[i]),
         .in_valid  (oct_v[i]),
         .in_item   (oct_item[i]),
         .out_valid (oct_v[i+1]),
         .out_item  (oct_item[i+1])
      );
   end

   vnf_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (oct_v[MAX_OCTAVES]),
      .in_acc    (oct_item[MAX_OCTAVES].acc),
      .in_wsum   (oct_item[MAX_OCTAVES].wsum),
      .out_valid (div_v),
      .out_q     (div_q)
   );

   function automatic logic [7:0] chan_mix(logic [7:0] a, logic [7:0] b,
                                           logic [FRAC_BITS-1:0] q);
      logic [23:0] p;
      if (b >= a) begin
         p = {8'b0, q} * {16'b0, b - a};
         return a + p[23:16];
      end
      p = {8'b0, q} * {16'b0, a - b} + 24'h00ffff;
      return a - p[23:16];
   endfunction

   always_comb begin
      cs_in.level = div_q[FRAC_BITS-1 -: 16];
      for (int k = 0; k < 4; k++) begin
         cs_in.rgba[8*k +: 8] = chan_mix(color_start_ff[8*k +: 8],
                                         color_end_ff[8*k +: 8], div_q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_v_ff <= 1'b0;
      end else if (en) begin
         cs_v_ff <= div_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cs_ff <= cs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!skid_v_ff) begin
         if (!out_v_ff || rsp_tready) begin
            out_v_ff <= cs_v_ff;
            out_ff   <= cs_ff;
         end else if (cs_v_ff) begin
            skid_v_ff <= 1'b1;
            skid_ff   <= cs_ff;
         end
      end else if (rsp_tready) begin
         out_ff    <= skid_ff;
         skid_v_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("output buffer holds an item behind an empty output register");

   a_park_in_skid: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_tready && cs_v_ff && !skid_v_ff) |=> skid_v_ff)
      else $error("finished item was not parked while the output stalled");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && rsp_tready) |=> (!skid_v_ff && out_v_ff && out_ff == $past(skid_ff)))
      else $error("parked item was not moved to the output register");

endmodule
`default_nettype wire

// File: test/value_noise_fbm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_noise_fbm_checker : scoreboard for the value-noise shader
// Tracks register writes, predicts the colour and noise level of every
// accepted pixel item and compares each result item against the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module value_noise_fbm_checker import vnf_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [47:0] rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   output int               errors,
   output int               pending,
   output int               results_seen
);

   typedef struct packed {
      logic [15:0] level;
      logic [31:0] rgba;
   } shade_type;

   logic [31:0] seed_q, step_x_q, step_y_q, colour_a_q, colour_b_q;
   logic [3:0]  octaves_q;
   logic [15:0] lacunarity_q, persistence_q;
   shade_type   shade_queue[$];

   assign pending = shade_queue.size();

   function automatic logic [63:0] lattice_value(logic [31:0] cx, logic [31:0] cy,
                                                 logic [31:0] s);
      logic [31:0] h;
      h = cx * HASH_KX + cy * HASH_KY + s * HASH_KS;
      h = (h ^ (h >> 13)) * HASH_KS;
      h = h ^ (h >> 16);
      return 64'((h & HASH_MASK) >> 15);
   endfunction

   function automatic logic [63:0] scaled(logic [63:0] c, logic [63:0] freq);
      logic [63:0] r;
      r = (((c >> 24) * freq) << 8) + (((c & 64'hFF_FFFF) * freq) >> 16);
      return r & 64'h00FF_FFFF_FFFF_FFFF;
   endfunction

   function automatic logic [63:0] smooth(logic [63:0] f);
      logic [63:0] f2;
      f2 = (f * f) >> 16;
      return (f2 * (64'd196608 - 2 * f)) >> 16;
   endfunction

   function automatic logic [63:0] lerp(logic [63:0] a, logic [63:0] b, logic [63:0] t);
      return (a * (64'd65536 - t) + b * t) >> 16;
   endfunction

   function automatic logic [63:0] octave_value(logic [63:0] xc, logic [63:0] yc,
                                                logic [31:0] s);
      logic [31:0] ix, iy;
      logic [63:0] fx, fy;
      ix = xc[55:24];
      iy = yc[55:24];
      fx = smooth(64'(xc[23:8]));
      fy = smooth(64'(yc[23:8]));
      return lerp(lerp(lattice_value(ix, iy, s), lattice_value(ix + 1, iy, s), fx),
                  lerp(lattice_value(ix, iy + 1, s), lattice_value(ix + 1, iy + 1, s), fx),
                  fy);
   endfunction

   function automatic shade_type predict_shade(logic [15:0] px, logic [15:0] py);
      logic [63:0] x, y, freq, amp, acc, wsum, q, a, b, ch;
      int          count;
      shade_type   r;
      x = 64'(px) * 64'(step_x_q);
      y = 64'(py) * 64'(step_y_q);
      count = octaves_q;
      if (count == 0) count = 1;
      if (count > 8) count = 8;
      freq = 65536;
      amp = 65536;
      acc = 0;
      wsum = 0;
      for (int i = 0; i < count; i++) begin
         acc += octave_value(scaled(x, freq), scaled(y, freq), seed_q + SEED_STEP * i) * amp;
         wsum += amp;
         freq = (freq * lacunarity_q) >> 12;
         if (freq > 64'hFFFF_FFFF) freq = 64'hFFFF_FFFF;
         amp = (amp * persistence_q) >> 14;
         if (amp > 64'hFFFF_FFFF) amp = 64'hFFFF_FFFF;
      end
      q = acc / wsum;
      if (q > 65535) q = 65535;
      r.level = q[15:0];
      for (int k = 0; k < 4; k++) begin
         a = 64'(colour_a_q[8*k +: 8]);
         b = 64'(colour_b_q[8*k +: 8]);
         if (b >= a) ch = a + ((q * (b - a)) >> 16);
         else ch = a - ((q * (a - b) + 65535) >> 16);
         r.rgba[8*k +: 8] = ch[7:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      shade_type want, got;
      if (reset) begin
         seed_q <= 0;
         octaves_q <= 1;
         step_x_q <= 65536;
         step_y_q <= 65536;
         lacunarity_q <= 8192;
         persistence_q <= 8192;
         colour_a_q <= 0;
         colour_b_q <= 32'hFFFF_FFFF;
         shade_queue.delete();
         errors <= 0;
         results_seen <= 0;
      end else begin
         if (csr_we) begin
            case (vnf_reg_type'(csr_index))
               REG_SEED:        seed_q <= csr_wdata;
               REG_OCTAVES:     octaves_q <= csr_wdata[3:0];
               REG_STEP_X:      step_x_q <= csr_wdata;
               REG_STEP_Y:      step_y_q <= csr_wdata;
               REG_LACUNARITY:  lacunarity_q <= csr_wdata[15:0];
               REG_PERSISTENCE: persistence_q <= csr_wdata[15:0];
               REG_COLOR_START: colour_a_q <= csr_wdata;
               REG_COLOR_END:   colour_b_q <= csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            shade_queue.push_back(predict_shade(req_tdata[15:0], req_tdata[31:16]));
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            got = rsp_tdata;
            if (shade_queue.size() == 0) begin
               if (errors < 10)
                  $display("%0t: unexpected result item rgba=%h level=%h",
                           $realtime, got.rgba, got.level);
               errors <= errors + 1;
            end else begin
               want = shade_queue.pop_front();
               if (want.rgba !== got.rgba || want.level !== got.level) begin
                  if (errors < 10)
                     $display("%0t: mismatch rgba exp %h got %h, level exp %h got %h",
                              $realtime, want.rgba, got.rgba, want.level, got.level);
                  errors <= errors + 1;
               end
            end
         end
      end
   end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb : top-level testbench for the value-noise shader
// Drives pixel items under several register settings, including the
// extremes, with random gaps and back-pressure, and lets the checker
// compare every result item with its prediction.
// ----------------------------------------------------------------------------
module tb;
   import vnf_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic        csr_we = 0;
   logic [2:0]  csr_index = 0;
   logic [31:0] csr_wdata = 0;
   int          errors, pending, results_seen;
   int          sender_idle = 35;
   int          receiver_idle = 60;
   logic        stall_wanted = 0;
   int          items_sent = 0;

   always #6 clock = ~clock;

   value_noise_fbm_shader i_dut (.*);

   value_noise_fbm_checker i_checker (.*);

   always @(posedge clock) begin
      int  stall_left;
      bit  stall_taken;
      if (reset) begin
         rsp_tready <= 0;
         stall_left = 0;
         stall_taken = 0;
      end else begin
         if (stall_wanted && !stall_taken) begin
            stall_left = 400;
            stall_taken = 1;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_idle);
         end
      end
   end

   task automatic send_pixel(logic [15:0] px, logic [15:0] py);
      while ($urandom_range(99) < sender_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic program_regs(logic [31:0] vals[8]);
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 0;
      @(posedge clock);
   endtask

   task automatic directed_corners();
      send_pixel(16'h0000, 16'h0000);
      send_pixel(16'hFFFF, 16'hFFFF);
      send_pixel(16'h0000, 16'hFFFF);
      send_pixel(16'hFFFF, 16'h0000);
      send_pixel(16'hAAAA, 16'h5555);
      send_pixel(16'h5555, 16'hAAAA);
   endtask

   initial begin
      logic [31:0] regs[8];
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      directed_corners();
      send_pixel(16'd1, 16'd1);
      drain();
      regs = '{32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'h0000_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0000_0000};
      program_regs(regs);
      directed_corners();
      drain();
      regs = '{32'h0, 32'd15, 32'h0, 32'h0100_0000, 32'h0, 32'h0, 32'h12345678, 32'h87654321};
      program_regs(regs);
      directed_corners();
      drain();
      regs = '{32'h1, 32'd9, 32'h0000_1000, 32'h0000_0100, 32'h1000, 32'h4000,
               32'h00FF_00FF, 32'hFF00_FF00};
      program_regs(regs);
      directed_corners();
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         if (phase < 4) begin
            sender_idle = 35;
            receiver_idle = 60;
         end else if (phase < 7) begin
            sender_idle = 60;
            receiver_idle = 35;
         end else begin
            sender_idle = 0;
            receiver_idle = 0;
         end
         regs[0] = $urandom;
         regs[1] = $urandom_range(15);
         regs[2] = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0004_0000);
         regs[3] = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0004_0000);
         regs[4] = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(4096, 12288);
         regs[5] = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(16384);
         regs[6] = $urandom;
         regs[7] = $urandom;
         program_regs(regs);
         if (phase == 8) stall_wanted = 1;
         for (int n = 0; n < 160; n++)
            send_pixel(16'($urandom), 16'($urandom));
         drain();
      end

      repeat (100) @(posedge clock);
      $display("Sent %0d pixel items over 14 register settings, %0d result items checked.",
               items_sent, results_seen);
      $display("Settings covered octave counts 0 to 15, extreme steps and reversed colours.");
      if (errors == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #(12 * 400000);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
